// ===== rtl/core/prp_pkg.sv =====
// ============================================================================
// prp_pkg: shared definitions for the packet rate policer
// Widths, configuration register indexes, reset values and the sequencer
// state type of the policer, and the request types for its iterative divider.
// ============================================================================
package prp_pkg;

    // Field and register widths.
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 16;
    localparam int TICK_W   = 32;
    localparam int MODE_W   = 2;
    localparam int BYTES_W  = 27;
    localparam int WBYTES_W = 28;
    localparam int TPS_W    = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Refill product rate * elapsed, and the divider that scales it.
    localparam int DIVIDEND_W = BYTES_W + TICK_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    // Quotient is clamped to this width before it joins the bucket.
    localparam int QSAT_W     = BYTES_W + 1;
    localparam int TSUM_W     = QSAT_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITER_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_BYTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 3'd4;

    // Limiter modes.
    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WINDOW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BUCKET = 2'd2;

    // Reset values.
    localparam logic [BYTES_W-1:0] RESET_RATE  = 27'd1250000;
    localparam logic [BYTES_W-1:0] RESET_BURST = 27'd25000;
    localparam logic [TPS_W-1:0]   RESET_TPS   = 16'd1000;

    // Policer sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WINDOW,
        S_MULT,
        S_DIV_START,
        S_DIV_WAIT,
        S_REFILL,
        S_SPEND,
        S_DONE
    } prp_state_t;

    // Request to the divider and its status back.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [TPS_W-1:0]      divisor;
    } prp_div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } prp_div_rsp_t;

endpackage

// ===== rtl/core/prp_div.sv =====
// ============================================================================
// prp_div: iterative unsigned divider
// Restoring shift-subtract division, one quotient bit per cycle. The
// quotient builds up in the dividend register as the dividend shifts out.
// ============================================================================
module prp_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  prp_pkg::prp_div_req_t req,
    output prp_pkg::prp_div_rsp_t rsp
);
    import prp_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_CNT_W-1:0]  cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [TPS_W-1:0]      rem_reg;
    logic [TPS_W-1:0]      rem_next;
    logic [TPS_W-1:0]      dvs_reg;
    logic [TPS_W-1:0]      dvs_next;

    logic [TPS_W:0]        shifted;
    logic [TPS_W:0]        diff;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    // Iteration control and datapath next values.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[TPS_W-1:0] : shifted[TPS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/packet_rate_policer.sv =====
// ============================================================================
// packet_rate_policer: per-source byte policer with window and token bucket
// Gives one accept/drop verdict per packet request; packets from the target
// source are policed by a fixed one-second window or by a token bucket.
// ============================================================================
// Sequence: unpoliced packets and mode pass go straight to the done state;
// window mode adds the window state, bucket mode the multiply, divider and
// refill and spend states. One request at a time: the next one is taken once
// the verdict is loaded; the bucket refill divides a 59-bit product one bit per cycle.
// Reset: registers take their documented reset values, the bucket is full
// at 25000 tokens, window and refill times are zero; no clearing pass.
module packet_rate_policer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [prp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prp_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [prp_pkg::ADDR_W-1:0]      source_addr,
    input  logic [prp_pkg::LEN_W-1:0]       total_length,
    input  logic [prp_pkg::TICK_W-1:0]      now_ticks,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            drop
);
    import prp_pkg::*;

    // Configuration registers.
    logic [ADDR_W-1:0]   target_addr_reg;
    logic [MODE_W-1:0]   limiter_mode_reg;
    logic [BYTES_W-1:0]  rate_bytes_reg;
    logic [BYTES_W-1:0]  burst_bytes_reg;
    logic [TPS_W-1:0]    tps_reg;

    // Policer state.
    logic [TICK_W-1:0]   window_start_reg;
    logic [WBYTES_W-1:0] window_bytes_reg;
    logic [BYTES_W-1:0]  bucket_tokens_reg;
    logic [TICK_W-1:0]   last_refill_reg;

    // Per-request working registers.
    prp_state_t          state_reg;
    prp_state_t          state_next;
    logic [LEN_W-1:0]    len_reg;
    logic [TICK_W-1:0]   now_reg;
    logic [DIVIDEND_W-1:0] product_reg;
    logic                verdict_reg;
    logic                out_valid_reg;
    logic                drop_reg;

    // Sequencer outputs.
    logic                accept;
    logic                div_start;
    logic                load_out;

    prp_div_req_t        div_req;
    prp_div_rsp_t        div_rsp;

    logic                policed;
    logic [TPS_W-1:0]    tps_eff;
    logic [TICK_W-1:0]   window_end;
    logic [TICK_W-1:0]   window_diff;
    logic                window_open;
    logic [WBYTES_W-1:0] window_base;
    logic [WBYTES_W:0]   window_sum;
    logic                window_ok;
    logic [TICK_W-1:0]   elapsed;
    logic                add_nz;
    logic [QSAT_W-1:0]   add_sat;
    logic [TSUM_W-1:0]   refill_sum;
    logic                spend_ok;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_addr_reg  <= '0;
            limiter_mode_reg <= MODE_PASS;
            rate_bytes_reg   <= RESET_RATE;
            burst_bytes_reg  <= RESET_BURST;
            tps_reg          <= RESET_TPS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_ADDR:   target_addr_reg  <= cfg_wdata[ADDR_W-1:0];
                CFG_LIMITER_MODE:  limiter_mode_reg <= cfg_wdata[MODE_W-1:0];
                CFG_RATE_BYTES:    rate_bytes_reg   <= cfg_wdata[BYTES_W-1:0];
                CFG_BURST_BYTES:   burst_bytes_reg  <= cfg_wdata[BYTES_W-1:0];
                CFG_TICKS_PER_SEC: tps_reg          <= cfg_wdata[TPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Match and derived constants.
    always_comb
    begin
        policed = (target_addr_reg != '0) && (source_addr == target_addr_reg);
        tps_eff = (tps_reg == '0) ? TPS_W'(1) : tps_reg;
    end

    // Window mode: a new window opens when now is strictly after start + tps.
    always_comb
    begin
        window_end  = window_start_reg + TICK_W'(tps_eff);
        window_diff = now_reg - window_end;
        window_open = (window_diff != '0) && !window_diff[TICK_W-1];
        window_base = window_open ? '0 : window_bytes_reg;
        window_sum  = {1'b0, window_base} + (WBYTES_W + 1)'(len_reg);
        window_ok   = window_sum <= (WBYTES_W + 1)'(rate_bytes_reg);
    end

    // Bucket mode: clamp the refill amount, then add it to the tokens.
    always_comb
    begin
        elapsed    = now_reg - last_refill_reg;
        add_nz     = |div_rsp.quotient;
        add_sat    = (|div_rsp.quotient[DIVIDEND_W-1:QSAT_W]) ? '1
                                                               : div_rsp.quotient[QSAT_W-1:0];
        refill_sum = TSUM_W'(bucket_tokens_reg) + TSUM_W'(add_sat);
        spend_ok   = bucket_tokens_reg >= BYTES_W'(len_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (policed && limiter_mode_reg == MODE_WINDOW)
                        state_next = S_WINDOW;
                    else if (policed && limiter_mode_reg == MODE_BUCKET)
                        state_next = S_MULT;
                    else
                        state_next = S_DONE;
                end
            end
            S_WINDOW:    state_next = S_DONE;
            S_MULT:      state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:  state_next = div_rsp.done ? S_REFILL : S_DIV_WAIT;
            S_REFILL:    state_next = S_SPEND;
            S_SPEND:     state_next = S_DONE;
            S_DONE:      state_next = (!out_valid_reg || !out_stall) ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            S_IDLE:      in_stall  = 1'b0;
            S_DIV_START: div_start = 1'b1;
            S_DONE:      load_out  = !out_valid_reg || !out_stall;
            default: ;
        endcase
        accept = in_valid && !in_stall;
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = product_reg;
    assign div_req.divisor  = tps_eff;

    prp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Control state and policer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            window_start_reg  <= '0;
            window_bytes_reg  <= '0;
            bucket_tokens_reg <= RESET_BURST;
            last_refill_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (state_reg == S_WINDOW)
            begin
                if (window_open)
                    window_start_reg <= now_reg;
                // A packet that fits is counted; otherwise a new window starts empty.
                if (window_ok)
                    window_bytes_reg <= window_sum[WBYTES_W-1:0];
                else if (window_open)
                    window_bytes_reg <= '0;
            end

            // Refill only when tokens were added; the clamp may also lower them.
            if (state_reg == S_REFILL && add_nz)
            begin
                last_refill_reg <= now_reg;
                if (refill_sum > TSUM_W'(burst_bytes_reg))
                    bucket_tokens_reg <= burst_bytes_reg;
                else
                    bucket_tokens_reg <= refill_sum[BYTES_W-1:0];
            end

            if (state_reg == S_SPEND && spend_ok)
                bucket_tokens_reg <= bucket_tokens_reg - BYTES_W'(len_reg);
        end
    end

    // Request payload, refill product and verdict.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg     <= total_length;
            now_reg     <= now_ticks;
            verdict_reg <= 1'b0;
        end
        if (state_reg == S_MULT)
            product_reg <= DIVIDEND_W'(rate_bytes_reg) * DIVIDEND_W'(elapsed);
        if (state_reg == S_WINDOW)
            verdict_reg <= !window_ok;
        if (state_reg == S_SPEND)
            verdict_reg <= !spend_ok;
        if (load_out)
            drop_reg <= verdict_reg;
    end

    assign out_valid = out_valid_reg;
    assign drop      = drop_reg;

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside the wait state");

    // A new verdict appears only from the final state of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("verdict raised without a finished request");

    // An accepted request blocks the input until it has been handled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input reopened right after a request");

    // The divider is never started while it is still busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule
